[rtl/tcce_pkg.sv]
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types and constants of the text console cursor engine.
// ----------------------------------------------------------------------------
`default_nettype none

package tcce_pkg;

    localparam int DEF_COLUMNS    = 80;
    localparam int DEF_ROWS       = 25;
    localparam int DEF_ATTR_DEPTH = 16;

    localparam int ADDR_W  = 11;
    localparam int CROW_W  = 5;
    localparam int ATTR_W  = 8;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 4;
    localparam int POS_W   = 8;
    localparam int ERR_W   = 2;

    localparam logic [ATTR_W-1:0] DEFAULT_ATTR = 8'h07;

    localparam logic [CHAR_W-1:0] CH_BS  = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;

    typedef enum logic [2:0] {
        CMD_PUT_CHAR     = 3'd0,
        CMD_SET_ATTR     = 3'd1,
        CMD_PUSH_ATTR    = 3'd2,
        CMD_POP_ATTR     = 3'd3,
        CMD_SET_CURSOR   = 3'd4,
        CMD_CLEAR_SCREEN = 3'd5
    } cmd_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE      = 2'd0,
        ERR_OVERFLOW  = 2'd1,
        ERR_UNDERFLOW = 2'd2
    } err_t;

    typedef struct packed {
        logic              wr;
        logic [ADDR_W-1:0] waddr;
        logic [CHAR_W-1:0] chr;
        logic              clr;
        logic [CROW_W-1:0] clr_row;
        logic              all;
        logic [ADDR_W-1:0] offset;
    } cur_res_t;

endpackage

`default_nettype wire

[rtl/tcce_cursor.sv]
// ----------------------------------------------------------------------------
// tcce_cursor
// Cursor column and row registers with the per-command cursor update.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_cursor
    import tcce_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [2:0]        command,
    input  wire logic [CHAR_W-1:0] char_code,
    input  wire logic [POS_W-1:0]  cursor_col,
    input  wire logic [POS_W-1:0]  cursor_row,
    output cur_res_t               res
);

    localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [CW-1:0] column_reg, column_next;
    logic [RW-1:0] row_reg, row_next;

    function automatic logic [ADDR_W-1:0] offs(input logic [7:0] c, input logic [5:0] r);
        logic [13:0] s;
        s = 14'(c) + 14'(r) * 14'(COLUMNS);
        return s[ADDR_W-1:0];
    endfunction

    logic [7:0] col;
    logic [7:0] ncol;
    logic [5:0] rw;
    logic [5:0] nrow;

    always_comb
    begin
        col       = 8'(column_reg);
        rw        = 6'(row_reg);
        ncol      = col;
        nrow      = rw;
        res       = '0;
        res.chr   = char_code;
        unique case (command)
            CMD_PUT_CHAR:
            begin
                if (char_code == CH_LF)
                begin
                    nrow    = rw + 6'd1;
                    res.clr = 1'b1;
                end
                else if (char_code == CH_CR)
                begin
                    ncol = 8'd0;
                end
                else if (char_code == CH_TAB)
                begin
                    ncol = {col[7:3] + 5'd1, 3'b000};
                end
                else if (char_code == CH_BS)
                begin
                    if (col != 8'd0)
                    begin
                        ncol = col - 8'd1;
                    end
                    else if (rw != 6'd0)
                    begin
                        nrow = rw - 6'd1;
                        ncol = 8'(COLUMNS - 1);
                    end
                    res.wr    = 1'b1;
                    res.waddr = offs(ncol, nrow);
                    res.chr   = '0;
                end
                else
                begin
                    res.wr    = 1'b1;
                    res.waddr = offs(col, rw);
                    ncol      = col + 8'd1;
                end
                if (ncol >= 8'(COLUMNS))
                begin
                    ncol    = 8'd0;
                    nrow    = nrow + 6'd1;
                    res.clr = 1'b1;
                end
                if (nrow >= 6'(ROWS))
                begin
                    nrow = 6'd0;
                end
            end
            CMD_SET_CURSOR:
            begin
                ncol = (cursor_col > 8'(COLUMNS - 1)) ? 8'(COLUMNS - 1) : cursor_col;
                nrow = (cursor_row > 8'(ROWS - 1)) ? 6'(ROWS - 1) : cursor_row[5:0];
            end
            CMD_CLEAR_SCREEN:
            begin
                res.all = 1'b1;
                ncol    = 8'd0;
                nrow    = 6'd0;
            end
            default:
            begin
            end
        endcase
        if (!res.wr)
        begin
            res.chr = '0;
        end
        res.clr_row = res.clr ? nrow[CROW_W-1:0] : '0;
        res.offset  = offs(ncol, nrow);
        column_next = accept ? ncol[CW-1:0] : column_reg;
        row_next    = accept ? nrow[RW-1:0] : row_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            row_reg    <= '0;
        end
        else
        begin
            column_reg <= column_next;
            row_reg    <= row_next;
        end
    end

endmodule

`default_nettype wire

[rtl/tcce_attr_stack.sv]
// ----------------------------------------------------------------------------
// tcce_attr_stack
// Attribute stack in a synchronous memory with the stack level register.
// The top entry after each transfer is read or forwarded into registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_attr_stack
    import tcce_pkg::*;
#(
    parameter int ATTR_DEPTH = DEF_ATTR_DEPTH
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [2:0]        command,
    input  wire logic [ATTR_W-1:0] attr,
    output err_t                   err,
    output logic [ATTR_W-1:0]      top
);

    localparam int LW = (ATTR_DEPTH > 1) ? $clog2(ATTR_DEPTH) : 1;

    logic [ATTR_W-1:0] mem [ATTR_DEPTH];

    logic [LW-1:0]     level_reg, level_next;
    logic              e0_written_reg, e0_written_next;
    logic              fwd_reg;
    logic              dflt_reg;
    logic [ATTR_W-1:0] fwd_attr_reg;
    logic [ATTR_W-1:0] rdata_reg;

    logic [LW-1:0] lvl_n;
    logic          wen;
    logic [LW:0]   lvl_inc;

    always_comb
    begin
        lvl_n   = level_reg;
        wen     = 1'b0;
        err     = ERR_NONE;
        lvl_inc = {1'b0, level_reg} + (LW+1)'(1);
        unique case (command)
            CMD_SET_ATTR:
            begin
                wen = 1'b1;
            end
            CMD_PUSH_ATTR:
            begin
                if (lvl_inc >= (LW+1)'(ATTR_DEPTH))
                begin
                    err = ERR_OVERFLOW;
                end
                else
                begin
                    lvl_n = lvl_inc[LW-1:0];
                    wen   = 1'b1;
                end
            end
            CMD_POP_ATTR:
            begin
                if (level_reg == '0)
                begin
                    err = ERR_UNDERFLOW;
                end
                else
                begin
                    lvl_n = level_reg - LW'(1);
                end
            end
            default:
            begin
            end
        endcase
        level_next      = accept ? lvl_n : level_reg;
        e0_written_next = e0_written_reg | (accept && wen && lvl_n == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg      <= '0;
            e0_written_reg <= 1'b0;
        end
        else
        begin
            level_reg      <= level_next;
            e0_written_reg <= e0_written_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (wen)
            begin
                mem[lvl_n] <= attr;
            end
            rdata_reg    <= mem[lvl_n];
            fwd_reg      <= wen;
            fwd_attr_reg <= attr;
            dflt_reg     <= (lvl_n == '0) && !e0_written_reg;
        end
    end

    assign top = fwd_reg ? fwd_attr_reg : (dflt_reg ? DEFAULT_ATTR : rdata_reg);

endmodule

`default_nettype wire

[rtl/text_console_cursor_engine_unit.sv]
// ----------------------------------------------------------------------------
// text_console_cursor_engine_unit
// Text console engine: cursor tracking, attribute stack and cell requests.
// ----------------------------------------------------------------------------
// Commands arrive on the input channel (in_valid, in_stall) with their fields
// on separate ports. Each transfer produces exactly one result transfer on the
// output channel (out_valid, out_stall): an optional cell write, an optional
// row or screen fill request with its fill value, the cursor offset after the
// command and an error code.
// out_valid is set through the memory stage and the output register after the
// input transfer. The block accepts one command per cycle while in_stall is
// low; the attribute stack memory is read at the transfer edge and the result
// is registered in the output register when the memory stage advances.
// When the receiver stalls, one result waits in the output register and one
// more in the memory stage; after that in_stall rises until the output is
// taken.
// Reset clears the cursor to the origin, the stack level to zero and the top
// attribute to 0x07, and empties the pipeline. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_engine_unit
    import tcce_pkg::*;
#(
    parameter int COLUMNS    = DEF_COLUMNS,
    parameter int ROWS       = DEF_ROWS,
    parameter int ATTR_DEPTH = DEF_ATTR_DEPTH
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [2:0]         command,
    input  wire logic [CHAR_W-1:0]  char_code,
    input  wire logic [COLOR_W-1:0] fg_color,
    input  wire logic [COLOR_W-1:0] bg_color,
    input  wire logic [POS_W-1:0]   cursor_col,
    input  wire logic [POS_W-1:0]   cursor_row,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    cell_write,
    output logic [ADDR_W-1:0]       cell_address,
    output logic [15:0]             cell_value,
    output logic                    clear_row_valid,
    output logic [CROW_W-1:0]       clear_row,
    output logic                    clear_all,
    output logic [15:0]             fill_value,
    output logic [ADDR_W-1:0]       cursor_offset,
    output logic [ERR_W-1:0]        error_code
);

    logic              accept;
    logic              s1_adv;
    cur_res_t          cur_res;
    err_t              st_err;
    logic [ATTR_W-1:0] top;

    logic              s1_valid_reg, s1_valid_next;
    cur_res_t          s1_res_reg;
    err_t              s1_err_reg;
    logic              out_valid_reg, out_valid_next;

    assign accept   = in_valid && !in_stall;
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_adv;

    tcce_cursor #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_cursor (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .command    (command),
        .char_code  (char_code),
        .cursor_col (cursor_col),
        .cursor_row (cursor_row),
        .res        (cur_res)
    );

    tcce_attr_stack #(
        .ATTR_DEPTH (ATTR_DEPTH)
    ) u_attr_stack (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .command (command),
        .attr    ({bg_color, fg_color}),
        .err     (st_err),
        .top     (top)
    );

    always_comb
    begin
        s1_valid_next  = accept || (s1_valid_reg && !s1_adv);
        out_valid_next = s1_adv || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_res_reg <= cur_res;
            s1_err_reg <= st_err;
        end
        if (s1_adv)
        begin
            cell_write      <= s1_res_reg.wr;
            cell_address    <= s1_res_reg.waddr;
            cell_value      <= s1_res_reg.wr ? {top, s1_res_reg.chr} : 16'h0000;
            clear_row_valid <= s1_res_reg.clr;
            clear_row       <= s1_res_reg.clr_row;
            clear_all       <= s1_res_reg.all;
            fill_value      <= {top, 8'h00};
            cursor_offset   <= s1_res_reg.offset;
            error_code      <= s1_err_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire
